>>> rtl/core/grf_pkg.sv
// shared types and constants of the grid rectangle fill block
package grf_pkg;

   // fixed field widths of the request and response beats
   localparam int CoordWidth = 7;
   localparam int FillWidth  = 32;
   localparam int ReadWidth  = 32;
   localparam int ReqDataWidth = 64;

   // request kinds carried on req_tuser
   localparam logic ModeFill = 1'b0;
   localparam logic ModeRead = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_FILL = 3'b010,
      ST_READ = 3'b100
   } state_type;

   // command to the rectangle walker
   typedef struct packed {
      logic                  load;
      logic                  step;
      logic [CoordWidth-1:0] top;
      logic [CoordWidth-1:0] left;
      logic [CoordWidth-1:0] bottom;
      logic [CoordWidth-1:0] right;
   } walk_cmd_type;

   // current cell of the rectangle walker
   typedef struct packed {
      logic [CoordWidth-1:0] row;
      logic [CoordWidth-1:0] col;
      logic                  last;
   } walk_stat_type;

endpackage

>>> rtl/core/grid_rectangle_fill.sv
// top level of the grid rectangle fill block
//
// Holds a ROWS x COLS grid of WORD_WIDTH-bit words in one RAM.
// Request channel (req_): one beat is a fill (req_tuser = 0) or a read
// (req_tuser = 1). A fill writes fill_value into every cell of the
// clipped rectangle and gives no response beat; an empty rectangle
// writes nothing. A read gives one response beat on rsp_ with the word
// at (row_top, col_left), or zero when that cell lies outside the grid.
// A fill holds req_tready low while the walker writes its cells (the
// walker issues one RAM write a cycle); an empty fill leaves it high.
// A read does the registered RAM read first and then loads the response
// register; req_tready stays low until the response register is loaded.
// The response register parts the two channels: fills are taken while a
// response waits, but a further read waits in ST_READ until the receiver
// has taken the previous response beat.
// Reset clears the sequencer and the response valid; the grid contents
// are undefined until written, and nothing sweeps the RAM.
module grid_rectangle_fill #(
   parameter int ROWS       = 128,
   parameter int COLS       = 128,
   parameter int WORD_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // request beat
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // row_top[6:0], col_left[13:7], row_bottom[20:14], col_right[27:21],
   // fill_value[59:28], zero[63:60]
   input  logic [grf_pkg::ReqDataWidth-1:0] req_tdata,
   // mode[0]
   input  logic                             req_tuser,
   // response beat
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value[31:0]
   output logic [grf_pkg::ReadWidth-1:0]    rsp_tdata
);
   import grf_pkg::*;

   localparam int ColBits  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int RowBits  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int Depth    = ROWS * (2 ** ColBits);
   localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int RowMax   = ROWS - 1;
   localparam int ColMax   = COLS - 1;

   // request fields
   logic [CoordWidth-1:0] row_top, col_left, row_bottom, col_right;
   logic [FillWidth-1:0]  fill_value;
   logic                  mode;

   assign row_top    = req_tdata[CoordWidth-1:0];
   assign col_left   = req_tdata[2*CoordWidth-1:CoordWidth];
   assign row_bottom = req_tdata[3*CoordWidth-1:2*CoordWidth];
   assign col_right  = req_tdata[4*CoordWidth-1:3*CoordWidth];
   assign fill_value = req_tdata[4*CoordWidth+FillWidth-1:4*CoordWidth];
   assign mode       = req_tuser;

   state_type             state_ff, state_in;
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic                  oob_ff, oob_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ReadWidth-1:0]  rsp_data_ff, rsp_data_in;

   logic                  req_beat;
   logic [CoordWidth-1:0] bottom_clip, right_clip;
   logic                  fill_empty;
   logic                  read_oob;
   logic                  rsp_free;
   walk_cmd_type          walk_cmd;
   walk_stat_type         walk_stat;
   logic                  ram_wr_en, ram_rd_en;
   logic [AddrBits-1:0]   ram_wr_addr, ram_rd_addr;
   logic [WORD_WIDTH-1:0] ram_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // clip the rectangle to the grid and spot an empty one
   always_comb begin
      bottom_clip = row_bottom;
      right_clip  = col_right;
      if (32'(row_bottom) > RowMax) begin
         bottom_clip = CoordWidth'(RowMax);
      end
      if (32'(col_right) > ColMax) begin
         right_clip = CoordWidth'(ColMax);
      end
   end

   assign fill_empty = (row_top > bottom_clip) || (col_left > right_clip);
   assign read_oob   = (32'(row_top) > RowMax) || (32'(col_left) > ColMax);

   // walker command
   always_comb begin
      walk_cmd.load   = req_beat && (mode == ModeFill);
      walk_cmd.step   = (state_ff == ST_FILL);
      walk_cmd.top    = row_top;
      walk_cmd.left   = col_left;
      walk_cmd.bottom = bottom_clip;
      walk_cmd.right  = right_clip;
   end

   grf_walk u_walk (
      .clock (clock),
      .cmd   (walk_cmd),
      .stat  (walk_stat)
   );

   // grid RAM addressed as row and column fields
   assign ram_wr_en   = (state_ff == ST_FILL);
   assign ram_wr_addr = AddrBits'({RowBits'(walk_stat.row), ColBits'(walk_stat.col)});
   assign ram_rd_en   = req_beat && (mode == ModeRead);
   assign ram_rd_addr = AddrBits'({RowBits'(row_top), ColBits'(col_left)});

   grf_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (Depth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (word_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer and response register
   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      oob_in       = oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               word_in = WORD_WIDTH'(fill_value);
               oob_in  = read_oob;
               if (mode == ModeRead) begin
                  state_in = ST_READ;
               end else if (!fill_empty) begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            if (walk_stat.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = oob_ff ? '0 : ReadWidth'(ram_rd_data);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      oob_ff      <= oob_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/core/grf_ram.sv
// generic simple dual-port RAM with registered read
module grf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/grf_walk.sv
// rectangle walker: steps one cell a cycle through a clipped rectangle
module grf_walk (
   input  logic                  clock,
   input  grf_pkg::walk_cmd_type cmd,
   output grf_pkg::walk_stat_type stat
);
   import grf_pkg::*;

   logic [CoordWidth-1:0] row_ff, row_in;
   logic [CoordWidth-1:0] col_ff, col_in;
   logic [CoordWidth-1:0] left_ff, left_in;
   logic [CoordWidth-1:0] bottom_ff, bottom_in;
   logic [CoordWidth-1:0] right_ff, right_in;
   logic                  row_end;

   // end of the current row
   assign row_end = (col_ff == right_ff);

   // next cell: load the corner, or advance along the row and wrap
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      left_in   = left_ff;
      bottom_in = bottom_ff;
      right_in  = right_ff;
      if (cmd.load) begin
         row_in    = cmd.top;
         col_in    = cmd.left;
         left_in   = cmd.left;
         bottom_in = cmd.bottom;
         right_in  = cmd.right;
      end else if (cmd.step) begin
         if (row_end) begin
            col_in = left_ff;
            row_in = row_ff + CoordWidth'(1);
         end else begin
            col_in = col_ff + CoordWidth'(1);
         end
      end
   end

   // walker registers, payload only
   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      col_ff    <= col_in;
      left_ff   <= left_in;
      bottom_ff <= bottom_in;
      right_ff  <= right_in;
   end

   assign stat.row  = row_ff;
   assign stat.col  = col_ff;
   assign stat.last = row_end && (row_ff == bottom_ff);

endmodule

>>> rtl/core/grf_check.sv
// port checker for the grid rectangle fill block, bound to the top level
module grf_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [grf_pkg::ReadWidth-1:0]    rsp_tdata
);
   import grf_pkg::*;

   // no response beat is pending straight after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a read beat keeps the request side closed for its read cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == ModeRead)) |=> !req_tready)
      else $error("request taken during a read");

   // a response only appears out of the read cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response beat without a read");

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response beat changed");

endmodule

bind grid_rectangle_fill grf_check u_grf_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
